// ----- design/mpis_pkg.sv -----
package mpis_pkg;

  localparam int ADDR_W  = 32;
  localparam int PSIZE_W = 17;
  localparam int RADIX_W = 11;
  localparam int LVLC_W  = 4;
  localparam int IDX_W   = 10;
  localparam int OFF_W   = 16;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;
  localparam int CNT_W   = $clog2(ADDR_W);

  localparam logic [PSIZE_W-1:0] PSIZE_MAX = PSIZE_W'(65536);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(1024);

  localparam logic [PSIZE_W-1:0] PSIZE_RST = PSIZE_W'(64);
  localparam logic [RADIX_W-1:0] RADIX_RST = RADIX_W'(4);
  localparam logic [LVLC_W-1:0]  LVLC_RST  = LVLC_W'(2);

  localparam logic [1:0] REG_PAGE_SIZE   = 2'd0;
  localparam logic [1:0] REG_ENTRIES     = 2'd1;
  localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

  // effective settings: page size and radix after range limiting, level count raw
  typedef struct packed {
    logic [PSIZE_W-1:0] psize;
    logic [RADIX_W-1:0] radix;
    logic [LVLC_W-1:0]  levels_raw;
  } cfg_t;

endpackage

// ----- design/multilevel_page_index_split.sv -----
// Multilevel page index split. Each accepted word carries a logical address; the
// block divides it by the page size (any value, not only powers of two) and
// then peels the page number apart into base-E digits, E being the entries per
// table. It returns one result word per table level, outermost level first,
// each carrying the level, the table index, the page number and page offset,
// and a flag on the last level. All division runs through one bit-serial
// shift-subtract divider that yields one quotient bit per cycle. With C levels
// an item takes C+1 divisions, the address by the page size and then C by the
// table radix, followed by C result words (one per cycle when the output is
// not stalled). One address is in flight at a time; in_stall is high from
// acceptance until the last result word has been taken. Settings may only be
// written while the block is idle.
module multilevel_page_index_split #(
  parameter int MAX_LEVELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpis_pkg::ADDR_W-1:0]   in_logical_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpis_pkg::LVLC_W-1:0]   out_level_number,
  output logic [mpis_pkg::IDX_W-1:0]    out_table_index,
  output logic [mpis_pkg::ADDR_W-1:0]   out_page_number,
  output logic [mpis_pkg::OFF_W-1:0]    out_page_offset,
  output logic                          out_last_of_run,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpis_pkg::PADDR_W-1:0]  paddr,
  input  logic [mpis_pkg::DATA_W-1:0]   pwdata,
  output logic [mpis_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mpis_pkg::*;

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for an address
    S_PDIV = 4'b0010,  // address / page size
    S_LDIV = 4'b0100,  // page number peeled one radix digit per division
    S_EMIT = 4'b1000   // results out, outermost level first
  } state_t;

  state_t             state_r, state_nxt;
  cfg_t               cfg;
  logic [LVLC_W-1:0]  levels;

  logic               div_start;
  logic [ADDR_W-1:0]  div_dividend;
  logic [PSIZE_W-1:0] div_divisor;
  logic               div_done;
  logic [ADDR_W-1:0]  div_quo;
  logic [OFF_W-1:0]   div_rem;

  logic [ADDR_W-1:0]  pnum_r;
  logic [OFF_W-1:0]   poff_r;
  logic [IDX_W-1:0]   dig_r [MAX_LEVELS];
  logic [LVL_W-1:0]   k_r;
  logic [LVLC_W-1:0]  lvl_r;
  logic [LVLC_W-1:0]  rd_sel;
  logic               in_acc;
  logic               out_acc;
  logic               last_digit;
  logic               last_lvl;

  mpis_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpis_serdiv u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // level count limited to 1..MAX_LEVELS
  always_comb begin
    if (cfg.levels_raw == '0) begin
      levels = LVLC_W'(1);
    end else if ({1'b0, cfg.levels_raw} > (LVLC_W + 1)'(MAX_LEVELS)) begin
      levels = LVLC_W'(MAX_LEVELS);
    end else begin
      levels = cfg.levels_raw;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid & ~in_stall;
  assign out_valid  = (state_r == S_EMIT);
  assign out_acc    = out_valid & ~out_stall;
  assign last_digit = (LVLC_W'(k_r) == levels - 1'b1);
  assign last_lvl   = (lvl_r == levels);

  // the divider is restarted on the word it just produced: first the address,
  // then each successive quotient by the table radix. digit k is the index
  // for level C-k; an oversized power simply gives a zero quotient here
  always_comb begin
    div_start    = 1'b0;
    div_dividend = in_logical_address;
    div_divisor  = cfg.psize;
    unique case (state_r)
      S_IDLE: div_start = in_acc;
      S_PDIV: begin
        div_start    = div_done;
        div_dividend = div_quo;
        div_divisor  = PSIZE_W'(cfg.radix);
      end
      S_LDIV: begin
        div_start    = div_done & ~last_digit;
        div_dividend = div_quo;
        div_divisor  = PSIZE_W'(cfg.radix);
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_PDIV;
      S_PDIV: if (div_done) state_nxt = S_LDIV;
      S_LDIV: if (div_done && last_digit) state_nxt = S_EMIT;
      S_EMIT: if (out_acc && last_lvl) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      lvl_r   <= LVLC_W'(1);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PDIV && div_done) begin
        k_r <= '0;
      end else if (state_r == S_LDIV && div_done) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == S_LDIV && div_done && last_digit) begin
        lvl_r <= LVLC_W'(1);
      end else if (out_acc) begin
        lvl_r <= lvl_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PDIV && div_done) begin
      pnum_r <= div_quo;
      poff_r <= div_rem;
    end
    if (state_r == S_LDIV && div_done) begin
      dig_r[k_r] <= div_rem[IDX_W-1:0];
    end
  end

  // level L takes digit C-L
  assign rd_sel = levels - lvl_r;

  assign out_level_number = lvl_r;
  assign out_table_index  = dig_r[rd_sel[LVL_W-1:0]];
  assign out_page_number  = pnum_r;
  assign out_page_offset  = poff_r;
  assign out_last_of_run  = last_lvl;

  a_emit_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lvl_r >= LVLC_W'(1)) && (lvl_r <= levels))
    else $error("result level outside the configured levels");

  a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_PDIV) || (state_r == S_LDIV))
    else $error("divider finished while no division was pending");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && last_lvl) |=> (state_r == S_IDLE))
    else $error("block did not return to idle after the last level");

  a_first_level_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LDIV && state_nxt == S_EMIT) |=> (lvl_r == LVLC_W'(1)))
    else $error("result run did not start at the outermost level");

endmodule

// ----- design/mpis_cfg.sv -----
module mpis_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpis_pkg::PADDR_W-1:0]  paddr,
  input  logic [mpis_pkg::DATA_W-1:0]   pwdata,
  output logic [mpis_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mpis_pkg::cfg_t                cfg
);
  import mpis_pkg::*;

  logic [PSIZE_W-1:0] psize_r;
  logic [RADIX_W-1:0] radix_r;
  logic [LVLC_W-1:0]  lvlc_r;
  logic               wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= PSIZE_RST;
      radix_r <= RADIX_RST;
      lvlc_r  <= LVLC_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_PAGE_SIZE:   psize_r <= pwdata[PSIZE_W-1:0];
        REG_ENTRIES:     radix_r <= pwdata[RADIX_W-1:0];
        REG_LEVEL_COUNT: lvlc_r  <= pwdata[LVLC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PAGE_SIZE:   prdata = DATA_W'(psize_r);
      REG_ENTRIES:     prdata = DATA_W'(radix_r);
      REG_LEVEL_COUNT: prdata = DATA_W'(lvlc_r);
      default:         prdata = '0;
    endcase
  end

  // zero and oversized page size and radix values are pulled into range; the level count passes raw
  always_comb begin
    if (psize_r == '0)            cfg.psize = PSIZE_W'(1);
    else if (psize_r > PSIZE_MAX) cfg.psize = PSIZE_MAX;
    else                          cfg.psize = psize_r;
    if (radix_r == '0)            cfg.radix = RADIX_W'(1);
    else if (radix_r > RADIX_MAX) cfg.radix = RADIX_MAX;
    else                          cfg.radix = radix_r;
    cfg.levels_raw = lvlc_r;
  end

endmodule

// ----- design/mpis_serdiv.sv -----
module mpis_serdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mpis_pkg::ADDR_W-1:0]   dividend,
  input  logic [mpis_pkg::PSIZE_W-1:0]  divisor,
  output logic                          done,
  output logic [mpis_pkg::ADDR_W-1:0]   quotient,
  output logic [mpis_pkg::OFF_W-1:0]    remainder
);
  import mpis_pkg::*;

  logic [ADDR_W-1:0]  dsr_r, dsr_nxt;
  logic [OFF_W-1:0]   rem_r, rem_nxt;
  logic [PSIZE_W-1:0] dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [OFF_W:0]     trial;
  logic [OFF_W:0]     diff;
  logic               ge;

  // restoring division, one quotient bit per cycle
  assign trial   = {rem_r, dsr_r[ADDR_W-1]};
  assign ge      = trial >= dvs_r;
  assign diff    = trial - dvs_r;
  assign rem_nxt = ge ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
  assign dsr_nxt = {dsr_r[ADDR_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(ADDR_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dsr_r <= dsr_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dsr_r;
  assign remainder = rem_r;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mpis_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 320;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 12;

  // one result word as the block should return it
  typedef struct {
    logic [LVLC_W-1:0] level_number;
    logic [IDX_W-1:0]  table_index;
    logic [ADDR_W-1:0] page_number;
    logic [OFF_W-1:0]  page_offset;
    logic              last_of_run;
  } split_word_t;

  // clock, reset and every block input start at known values
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [ADDR_W-1:0] in_logical_address = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;

  logic in_stall;
  logic out_valid;
  logic [LVLC_W-1:0] out_level_number;
  logic [IDX_W-1:0] out_table_index;
  logic [ADDR_W-1:0] out_page_number;
  logic [OFF_W-1:0] out_page_offset;
  logic out_last_of_run;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // shadow copy of the settings as last written
  logic [PSIZE_W-1:0] cfg_page_size = PSIZE_RST;
  logic [RADIX_W-1:0] cfg_entries = RADIX_RST;
  logic [LVLC_W-1:0] cfg_levels = LVLC_RST;

  logic [ADDR_W-1:0] pending_addrs[$];
  split_word_t expected_splits[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  // when set, neither side idles nor stalls
  bit calm = 1'b0;

  multilevel_page_index_split u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_logical_address(in_logical_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level_number  (out_level_number),
    .out_table_index   (out_table_index),
    .out_page_number   (out_page_number),
    .out_page_offset   (out_page_offset),
    .out_last_of_run   (out_last_of_run),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // each roll idles a side with a chance of 31 in a hundred, never while calm is set
  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 31);
  endfunction

  function automatic bit block_busy();
    return pending_addrs.size() != 0 || in_valid || expected_splits.size() != 0;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // split one address into its per-level words under the current settings
  function automatic void split_address(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] psize;
    logic [RADIX_W-1:0] radix;
    logic [LVLC_W-1:0] levels;
    logic [ADDR_W-1:0] pnum;
    logic [ADDR_W-1:0] poff;
    longint unsigned divisor;
    bit too_big;
    split_word_t w;
    // out-of-range settings are pulled back to the nearest legal value
    psize = (cfg_page_size == 0) ? 1 :
            (cfg_page_size > PSIZE_MAX) ? ADDR_W'(PSIZE_MAX) : ADDR_W'(cfg_page_size);
    radix = (cfg_entries == 0) ? 1 : (cfg_entries > RADIX_MAX) ? RADIX_MAX : cfg_entries;
    levels = (cfg_levels == 0) ? 1 : (cfg_levels > 8) ? 8 : cfg_levels;
    pnum = addr / psize;
    poff = addr % psize;
    for (int lvl = 1; lvl <= levels; lvl++) begin
      // radix^(levels-lvl) formed at 64 bits; beyond 32 bits the index is zero
      divisor = 1;
      too_big = 1'b0;
      for (int k = 0; k < levels - lvl; k++) begin
        if (!too_big) begin
          divisor = divisor * radix;
          if (divisor > 64'hFFFF_FFFF) too_big = 1'b1;
        end
      end
      w.level_number = LVLC_W'(lvl);
      w.table_index = too_big ? '0 : IDX_W'((longint'(pnum) / divisor) % radix);
      w.page_number = pnum;
      w.page_offset = OFF_W'(poff);
      w.last_of_run = (lvl == levels);
      expected_splits.push_back(w);
    end
  endfunction

  // compare an accepted result word with the oldest expected word
  task automatic compare_split();
    split_word_t w;
    if (expected_splits.size() == 0) begin
      flag_mismatch($sformatf("result word level %0d with nothing expected",
                              out_level_number));
    end else begin
      w = expected_splits.pop_front();
      if (out_level_number !== w.level_number)
        flag_mismatch($sformatf("level_number got %0d want %0d",
                                out_level_number, w.level_number));
      if (out_table_index !== w.table_index)
        flag_mismatch($sformatf("table_index got %0d want %0d (level %0d)",
                                out_table_index, w.table_index, w.level_number));
      if (out_page_number !== w.page_number)
        flag_mismatch($sformatf("page_number got %h want %h",
                                out_page_number, w.page_number));
      if (out_page_offset !== w.page_offset)
        flag_mismatch($sformatf("page_offset got %h want %h",
                                out_page_offset, w.page_offset));
      if (out_last_of_run !== w.last_of_run)
        flag_mismatch($sformatf("last_of_run got %b want %b (level %0d)",
                                out_last_of_run, w.last_of_run, w.level_number));
    end
  endtask

  // input driver: a word stays put until accepted, then the next one may follow
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) split_address(in_logical_address);
      if (!in_valid || !in_stall) begin
        if (pending_addrs.size() != 0 && !idle_roll()) begin
          in_valid <= 1'b1;
          in_logical_address <= pending_addrs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) compare_split();
      out_stall <= idle_roll();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // setup cycle then access cycle; pready is sampled on the access edge
  task automatic apb_write(input logic [1:0] reg_sel, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for every word to come back and the block to go quiet
  task automatic settle();
    while (block_busy()) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // settings are only touched while nothing is in flight
  task automatic program_settings(input logic [DATA_W-1:0] ps, input logic [DATA_W-1:0] en,
                                  input logic [DATA_W-1:0] lc);
    settle();
    apb_write(REG_PAGE_SIZE, ps);
    cfg_page_size = ps[PSIZE_W-1:0];
    apb_write(REG_ENTRIES, en);
    cfg_entries = en[RADIX_W-1:0];
    apb_write(REG_LEVEL_COUNT, lc);
    cfg_levels = lc[LVLC_W-1:0];
    @(negedge clk);
  endtask

  // addresses lean toward the ends of the range where carries matter
  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(3))
      0: return ADDR_W'($urandom_range(0, 255));
      1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_page_size();
    case ($urandom_range(9))
      0: return 1 << $urandom_range(16);
      7: return $urandom_range(1, 16);
      8: return 0;
      9: return $urandom_range(65537, 131071);
      default: return $urandom_range(1, 65536);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_entries();
    case ($urandom_range(9))
      0: return 1 << $urandom_range(10);
      6, 7: return $urandom_range(2, 16);
      8: return 0;
      9: return $urandom_range(1025, 2047);
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  initial begin
    // reset held from the start, released on a clock edge
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: 64-byte pages, 4 entries, 2 levels
    pending_addrs.push_back(32'h0000_0000);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'h0000_003F);
    pending_addrs.push_back(32'h0000_0040);
    pending_addrs.push_back(32'hAAAA_AAAA);
    pending_addrs.push_back(32'h5555_5555);

    // zero page size, zero radix and zero levels all fall back to one
    program_settings(0, 0, 0);
    pending_addrs.push_back(32'h0000_0000);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'h0000_3039);

    // every register bit set: oversized page, oversized radix, too many levels
    program_settings(32'h1_FFFF, 32'h7FF, 32'hF);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'h0000_0000);
    pending_addrs.push_back(32'h1234_5678);

    // largest legal settings, the upper levels see a divisor past 32 bits
    program_settings(65536, 1024, 8);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'h0001_0000);

    // byte pages, binary radix, eight levels
    program_settings(1, 2, 8);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'h8000_0001);

    // page size and radix that are not powers of two
    program_settings(3, 10, 4);
    pending_addrs.push_back(32'h0000_0000);
    pending_addrs.push_back(32'h0000_0002);
    pending_addrs.push_back(32'h0000_0003);
    pending_addrs.push_back(32'h0000_752F);
    pending_addrs.push_back(32'hFFFF_FFFF);

    // 1024^4 at the outermost of five levels overflows 32 bits
    program_settings(1, 1024, 5);
    pending_addrs.push_back(32'hFFFF_FFFF);
    pending_addrs.push_back(32'hDEAD_BEEF);

    // random settings, each phase drained before the next write
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_settings(rand_page_size(), rand_entries(),
                       ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
      calm = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) pending_addrs.push_back(rand_addr());
      settle();
      calm = 1'b0;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mpis_pkg.sv
design/mpis_cfg.sv
design/mpis_serdiv.sv
design/multilevel_page_index_split.sv
test/tb_top.sv
